FILE: rtl/core/rmf_pkg.sv
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared constants and types of the row median filter: window geometry,
// pixel type, cell control and the registered rank lane record.
// ----------------------------------------------------------------------------
package rmf_pkg;

    localparam int MAX_HALF  = 7;
    localparam int WIN_DEPTH = 2 * MAX_HALF + 1;
    localparam int PIX_W     = 8;
    localparam int SIZE_W    = 4;
    localparam int HALF_W    = $clog2(MAX_HALF + 1);
    localparam int IDX_W     = $clog2(WIN_DEPTH);
    localparam int RANK_W    = $clog2(WIN_DEPTH);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(3);

    typedef logic [PIX_W-1:0]  pixel_t;
    typedef logic [HALF_W-1:0] half_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [RANK_W-1:0] rank_t;

    typedef pixel_t window_t [WIN_DEPTH];

    typedef struct packed {
        logic fill;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        pixel_t value;
        rank_t  rank;
        logic   active;
    } lane_t;

endpackage

FILE: rtl/core/row_median_filter.sv
// ----------------------------------------------------------------------------
// row_median_filter
// Horizontal median filter over a row of 8-bit pixels with edge replication.
// ----------------------------------------------------------------------------
// One pixel is taken per cycle while m_ready is high and no flush is under
// way; each result that a transfer (or flush step) causes is registered in
// the window cells, then in the rank lanes, then in the output register. The
// window is a chain of cells shifting once per step; every lane ranks its
// entry against the others in one registered stage. After a pixel flagged
// row_end, s_ready stays low for h = window_size/2 flush steps while the last
// pixel is shifted in again to flush the remaining results; a held result
// stretches a step until m_ready returns. Write window_size only when no
// results are outstanding; it is taken at once, without refilling.
// ----------------------------------------------------------------------------
module row_median_filter (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [rmf_pkg::SIZE_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rmf_pkg::pixel_t       s_pixel,
    input  logic                  s_row_end,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rmf_pkg::pixel_t       m_median,
    output logic                  m_last_of_row
);
    import rmf_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    half_t             half;
    logic              even;

    half_t  pos_reg, pos_next;
    half_t  plast_reg, plast_next;
    half_t  k_reg, k_next;
    logic   flush_reg, flush_next;
    logic   v1_reg, v1_next, l1_reg, l1_next;
    logic   v2_reg, l2_reg;
    logic   out_valid_reg;
    pixel_t median_reg, median_next;
    logic   last_reg;

    logic       advance, accept, flush_step;
    cell_ctrl_t cell_ctrl;
    pixel_t     shift_in;
    window_t    window;
    lane_t      lanes [WIN_DEPTH];

    logic [SIZE_W-1:0] half_raw;
    pixel_t            sel_hi, sel_lo;
    logic [PIX_W:0]    pair_sum;

    always_comb begin
        half_raw = size_reg >> 1;
        if (half_raw > SIZE_W'(MAX_HALF)) begin
            half = half_t'(MAX_HALF);
        end else begin
            half = half_t'(half_raw);
        end
        even = (size_reg != '0) && !size_reg[0];
    end

    assign advance    = !out_valid_reg || m_ready;
    assign s_ready    = advance && !flush_reg;
    assign accept     = s_valid && s_ready;
    assign flush_step = advance && flush_reg;

    assign cell_ctrl.fill  = accept && (pos_reg == '0);
    assign cell_ctrl.shift = (accept && (pos_reg != '0)) || flush_step;
    assign shift_in        = accept ? s_pixel : window[0];

    always_comb begin
        pos_next   = pos_reg;
        plast_next = plast_reg;
        k_next     = k_reg;
        flush_next = flush_reg;
        v1_next    = v1_reg;
        l1_next    = l1_reg;
        if (advance) begin
            v1_next = 1'b0;
            l1_next = 1'b0;
        end
        if (accept) begin
            v1_next = (pos_reg >= half);
            l1_next = s_row_end && (half == '0);
            if (s_row_end) begin
                pos_next = '0;
                if (half != '0) begin
                    flush_next = 1'b1;
                    k_next     = half_t'(1);
                    plast_next = pos_reg;
                end
            end else if (pos_reg < half_t'(MAX_HALF)) begin
                pos_next = pos_reg + half_t'(1);
            end
        end else if (flush_step) begin
            v1_next = ({1'b0, plast_reg} + {1'b0, k_reg}) >= {1'b0, half};
            l1_next = (k_reg == half);
            if (k_reg == half) begin
                flush_next = 1'b0;
            end else begin
                k_next = k_reg + half_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= SIZE_RESET;
            pos_reg       <= '0;
            flush_reg     <= 1'b0;
            k_reg         <= '0;
            plast_reg     <= '0;
            v1_reg        <= 1'b0;
            l1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            l2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
            end
            pos_reg   <= pos_next;
            flush_reg <= flush_next;
            k_reg     <= k_next;
            plast_reg <= plast_next;
            v1_reg    <= v1_next;
            l1_reg    <= l1_next;
            if (advance) begin
                v2_reg        <= v1_reg;
                l2_reg        <= l1_reg;
                out_valid_reg <= v2_reg;
                last_reg      <= l2_reg;
            end
        end
    end

    // window cells and rank lanes
    for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
        pixel_t prev_pixel;
        if (i == 0) begin : g_head
            assign prev_pixel = shift_in;
        end else begin : g_body
            assign prev_pixel = window[i-1];
        end

        rmf_cell u_cell (
            .aclk        (aclk),
            .ctrl        (cell_ctrl),
            .fill_pixel  (s_pixel),
            .shift_pixel (prev_pixel),
            .pixel_q     (window[i])
        );

        rmf_rank_lane u_lane (
            .aclk     (aclk),
            .advance  (advance),
            .lane_idx (idx_t'(i)),
            .half     (half),
            .window   (window),
            .lane_q   (lanes[i])
        );
    end

    // pick ranks h and h-1
    always_comb begin
        sel_hi = '0;
        sel_lo = '0;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            if (lanes[i].active && (lanes[i].rank == rank_t'(half))) begin
                sel_hi = sel_hi | lanes[i].value;
            end
            if (lanes[i].active && (half != '0) &&
                (lanes[i].rank == rank_t'(half - half_t'(1)))) begin
                sel_lo = sel_lo | lanes[i].value;
            end
        end
        pair_sum = {1'b0, sel_hi} + {1'b0, sel_lo};
        if (even) begin
            median_next = pair_sum[PIX_W:1];
        end else begin
            median_next = sel_hi;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            median_reg <= median_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_median      = median_reg;
    assign m_last_of_row = last_reg;

endmodule

FILE: rtl/core/rmf_cell.sv
// ----------------------------------------------------------------------------
// rmf_cell
// One window cell: holds a pixel, loads the fill pixel at row start or
// takes its neighbour's pixel on a shift.
// ----------------------------------------------------------------------------
module rmf_cell (
    input  logic                aclk,
    input  rmf_pkg::cell_ctrl_t ctrl,
    input  rmf_pkg::pixel_t     fill_pixel,
    input  rmf_pkg::pixel_t     shift_pixel,
    output rmf_pkg::pixel_t     pixel_q
);
    import rmf_pkg::*;

    pixel_t pixel_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.fill) begin
            pixel_reg <= fill_pixel;
        end else if (ctrl.shift) begin
            pixel_reg <= shift_pixel;
        end
    end

    assign pixel_q = pixel_reg;

endmodule

FILE: rtl/core/rmf_rank_lane.sv
// ----------------------------------------------------------------------------
// rmf_rank_lane
// Registered sort rank of one window entry among the active entries,
// ties broken by position so that every active entry gets its own rank.
// ----------------------------------------------------------------------------
module rmf_rank_lane (
    input  logic             aclk,
    input  logic             advance,
    input  rmf_pkg::idx_t    lane_idx,
    input  rmf_pkg::half_t   half,
    input  rmf_pkg::window_t window,
    output rmf_pkg::lane_t   lane_q
);
    import rmf_pkg::*;

    lane_t                 lane_reg;
    lane_t                 lane_next;
    logic [WIN_DEPTH-1:0]  less_vec;
    idx_t                  last_idx;
    pixel_t                own;

    always_comb begin
        last_idx = idx_t'(half) << 1;
        own      = window[lane_idx];
        for (int j = 0; j < WIN_DEPTH; j++) begin
            less_vec[j] = (idx_t'(j) != lane_idx) && (idx_t'(j) <= last_idx) &&
                          ((window[j] < own) ||
                           ((window[j] == own) && (idx_t'(j) < lane_idx)));
        end
        lane_next.value  = own;
        lane_next.rank   = rank_t'($countones(less_vec));
        lane_next.active = (lane_idx <= last_idx);
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_q = lane_reg;

endmodule

FILE: tb/row_median_filter_tb.sv
// ----------------------------------------------------------------------------
// row_median_filter_tb
// Self-checking bench for the row median filter. Rows of pixels are streamed
// through the valid/ready input under random idling and back-pressure, the
// window size is rewritten between phases (mid row too), and every filtered
// pixel is compared with a cycle-free model of the windowed median held in a
// small scoreboard class.
// ----------------------------------------------------------------------------

class row_median_scoreboard;

    typedef struct {
        rmf_pkg::pixel_t median;
        logic            last;
    } filtered_px_t;

    rmf_pkg::pixel_t              taps [rmf_pkg::WIN_DEPTH];
    int                           pos_in_row;
    logic [rmf_pkg::SIZE_W-1:0]   size_cfg;
    filtered_px_t                 expected_medians [$];
    int unsigned                  errors;
    int unsigned                  results_checked;

    function new();
        foreach (taps[i]) taps[i] = '0;
        pos_in_row      = 0;
        size_cfg        = rmf_pkg::SIZE_RESET;
        errors          = 0;
        results_checked = 0;
    endfunction

    task report(string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        errors++;
    endtask

    function void set_size(logic [rmf_pkg::SIZE_W-1:0] sz);
        size_cfg = sz;
    endfunction

    function int pending();
        return expected_medians.size();
    endfunction

    function void shift_tap(rmf_pkg::pixel_t px);
        for (int i = rmf_pkg::WIN_DEPTH - 1; i > 0; i--) taps[i] = taps[i-1];
        taps[0] = px;
    endfunction

    function rmf_pkg::pixel_t centre_median(int half);
        rmf_pkg::pixel_t sorted [rmf_pkg::WIN_DEPTH];
        rmf_pkg::pixel_t v;
        int n;
        int j;
        int sum;
        n = 2 * half + 1;
        for (int i = 0; i < n; i++) begin
            v = taps[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        // even sizes take the floored mean of the two middle ranks
        if (size_cfg != 0 && !size_cfg[0]) begin
            sum = int'(sorted[half-1]) + int'(sorted[half]);
            return rmf_pkg::pixel_t'(sum / 2);
        end
        return sorted[half];
    endfunction

    function void push_median(rmf_pkg::pixel_t med, logic last);
        filtered_px_t e;
        e.median = med;
        e.last   = last;
        expected_medians.insert(expected_medians.size(), e);
    endfunction

    function void take_pixel(rmf_pkg::pixel_t px, logic row_end);
        int half;
        int p;
        half = int'(size_cfg) / 2;
        if (half > rmf_pkg::MAX_HALF) half = rmf_pkg::MAX_HALF;
        p = pos_in_row;
        // first pixel of a row fills the window, replicating the left edge
        if (p == 0) begin
            foreach (taps[i]) taps[i] = px;
        end else begin
            shift_tap(px);
        end
        if (p >= half) push_median(centre_median(half), row_end && half == 0);
        if (row_end) begin
            for (int k = 1; k <= half; k++) begin
                shift_tap(px);
                if (p + k >= half) push_median(centre_median(half), k == half);
            end
            pos_in_row = 0;
        end else if (pos_in_row < rmf_pkg::MAX_HALF) begin
            pos_in_row++;
        end
    endfunction

    task check_median(rmf_pkg::pixel_t med, logic last);
        filtered_px_t e;
        if (expected_medians.size() == 0) begin
            report($sformatf("unexpected result median=%0d last=%0b", med, last));
        end else begin
            e = expected_medians.pop_front();
            results_checked++;
            if (med !== e.median)
                report($sformatf("median %0d, expected %0d", med, e.median));
            if (last !== e.last)
                report($sformatf("last_of_row %0b, expected %0b", last, e.last));
        end
    endtask

    task drop_missing();
        if (expected_medians.size() != 0) begin
            report($sformatf("%0d results never arrived", expected_medians.size()));
            expected_medians.delete();
        end
    endtask

endclass

module row_median_filter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rmf_pkg::*;

    typedef enum int unsigned {
        STYLE_NOISE,
        STYLE_FLAT,
        STYLE_EXTREME,
        STYLE_WIDE
    } pixel_style_e;

    localparam int          RANDOM_PIXELS = 240;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          DRAIN_LIMIT   = 4000;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [SIZE_W-1:0] cfg_wr_data   = '0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    pixel_t            s_pixel       = '0;
    logic              s_row_end     = 1'b0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    pixel_t            m_median;
    logic              m_last_of_row;

    row_median_scoreboard sb = new();

    bit          steady_flow   = 1'b0;
    int unsigned stall_left    = 0;
    int unsigned cycle_count   = 0;
    int unsigned pixels_sent   = 0;
    int unsigned rows_closed   = 0;
    int unsigned size_writes   = 0;
    int unsigned midrow_writes = 0;
    bit          row_open      = 1'b0;
    logic [15:0] sizes_seen    = 16'h0008;

    row_median_filter uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .s_row_end     (s_row_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_median      (m_median),
        .m_last_of_row (m_last_of_row)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver back-pressure, with the odd long stall
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (steady_flow) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(149) == 0) begin
            stall_left <= $urandom_range(20, 5);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= 24);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_median(m_median, m_last_of_row);
    end

    function automatic pixel_t pick_pixel(pixel_style_e style, pixel_t base);
        case (style)
            STYLE_FLAT:    return base + pixel_t'($urandom_range(3));
            STYLE_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
            default:       return pixel_t'($urandom_range(255));
        endcase
    endfunction

    // called at a clock edge; returns at the edge of the transfer
    task automatic send_pixel(pixel_t px, logic row_end);
        if (!steady_flow && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 24);
        end
        s_valid   <= 1'b1;
        s_pixel   <= px;
        s_row_end <= row_end;
        do @(posedge aclk); while (!s_ready);
        sb.take_pixel(px, row_end);
        pixels_sent++;
        row_open = !row_end;
        if (row_end) rows_closed++;
    endtask

    task automatic send_row(int len, bit close);
        pixel_style_e style;
        pixel_t       base;
        style = pixel_style_e'($urandom_range(3));
        base  = pixel_t'($urandom_range(255));
        for (int i = 0; i < len; i++)
            send_pixel(pick_pixel(style, base), close && i == len - 1);
    endtask

    // sender waits until every expected result has been seen or DRAIN_LIMIT runs out
    task automatic drain();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        sb.drop_missing();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] sz);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sz;
        @(posedge aclk);
        sb.set_size(sz);
        cfg_wr_en <= 1'b0;
        size_writes++;
        if (row_open) midrow_writes++;
        sizes_seen[sz] = 1'b1;
    endtask

    initial begin
        int unsigned target;
        int unsigned phase;
        int unsigned phase_goal;
        int unsigned phase_start;
        int          len;
        logic [SIZE_W-1:0] sz;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: default size, single-pixel row and extreme values
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b1);
        // size zero behaves as size one
        write_size(4'd0);
        send_pixel(8'h5A, 1'b1);
        send_pixel(8'hA5, 1'b0);
        send_pixel(8'h00, 1'b1);
        // widest window on short rows
        write_size(4'd15);
        send_pixel(8'h80, 1'b1);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'hFE, 1'b0);
        send_pixel(8'h03, 1'b0);
        send_pixel(8'h01, 1'b1);
        // even size averages the two middle ranks
        write_size(4'd2);
        send_pixel(8'd10, 1'b0);
        send_pixel(8'd11, 1'b0);
        send_pixel(8'd200, 1'b1);
        // size change in the middle of a row
        write_size(4'd5);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd9, 1'b0);
        send_pixel(8'd250, 1'b0);
        write_size(4'd9);
        send_pixel(8'd4, 1'b0);
        send_pixel(8'd6, 1'b0);
        send_pixel(8'hFF, 1'b1);
        write_size(4'd1);
        send_pixel(8'h33, 1'b0);
        send_pixel(8'hCC, 1'b1);

        // random rows over a run of window sizes
        target = pixels_sent + RANDOM_PIXELS;
        phase  = 0;
        while (pixels_sent < target) begin
            case (phase)
                0:       sz = 4'd15;
                1:       sz = 4'd1;
                2:       sz = 4'd0;
                3:       sz = 4'd14;
                default: sz = $urandom_range(15);
            endcase
            write_size(sz);
            steady_flow = (phase == 0);
            phase_goal  = steady_flow ? 60 : $urandom_range(40, 20);
            phase_start = pixels_sent;
            while (pixels_sent - phase_start < phase_goal) begin
                case ($urandom_range(19))
                    0:       len = 1;
                    1, 2, 3: len = $urandom_range(30, 13);
                    default: len = $urandom_range(12, 1);
                endcase
                // now and then leave the row open so the next size lands mid row
                send_row(len, !(pixels_sent - phase_start + len >= phase_goal
                                && $urandom_range(4) == 0));
            end
            steady_flow = 1'b0;
            phase++;
        end

        if (row_open) send_row(1, 1'b1);
        drain();

        $display("covered %0d pixels in %0d rows, %0d results checked",
                 pixels_sent, rows_closed, sb.results_checked);
        $display("%0d window size writes (%0d mid row), size mask %04h",
                 size_writes, midrow_writes, sizes_seen);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
